/* rtl/tlcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-line character display package
// Shared constants, command encodings and types of the display buffer.
// ----------------------------------------------------------------------------
package tlcd_pkg;

   localparam int DEF_COLUMNS = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0] SPACE_CODE = 8'h20;

   typedef enum logic [3:0] {
      ACT_WRITE = 4'd0,
      ACT_CLEAR = 4'd1,
      ACT_EOL   = 4'd2,
      ACT_UP    = 4'd3,
      ACT_DOWN  = 4'd4,
      ACT_RIGHT = 4'd5,
      ACT_LEFT  = 4'd6,
      ACT_SET   = 4'd7,
      ACT_READ  = 4'd8
   } action_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WRITE,
      OP_CLEAR,
      OP_EOL,
      OP_UP,
      OP_DOWN,
      OP_RIGHT,
      OP_LEFT,
      OP_SET,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic       row;
      logic [3:0] col;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } back_state_type;

endpackage

/* rtl/tlcd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module tlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tlcd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command front end
// Accepts command items, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
module tlcd_front #(
   parameter int COLUMNS = tlcd_pkg::DEF_COLUMNS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [3:0]        in_action,
   input  logic [7:0]        in_char,
   input  logic              in_row,
   input  logic [3:0]        in_col,
   output logic              cmd_valid,
   output tlcd_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import tlcd_pkg::*;

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            dec;
   logic               col_ok;
   logic               push;

   always_comb begin
      col_ok        = {28'd0, in_col} < 32'(COLUMNS);
      dec.char_code = in_char;
      dec.row       = in_row;
      dec.col       = in_col;
      case (in_action)
         ACT_WRITE: dec.op = OP_WRITE;
         ACT_CLEAR: dec.op = OP_CLEAR;
         ACT_EOL:   dec.op = OP_EOL;
         ACT_UP:    dec.op = OP_UP;
         ACT_DOWN:  dec.op = OP_DOWN;
         ACT_RIGHT: dec.op = OP_RIGHT;
         ACT_LEFT:  dec.op = OP_LEFT;
         ACT_SET:   dec.op = col_ok ? OP_SET : OP_NOP;
         ACT_READ:  dec.op = col_ok ? OP_READ : OP_NOP;
         default:   dec.op = OP_NOP;
      endcase
   end

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* rtl/tlcd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command back end
// Executes decoded commands on the character store and the cursor and
// registers one result item per command.
// ----------------------------------------------------------------------------
module tlcd_back #(
   parameter int COLUMNS = tlcd_pkg::DEF_COLUMNS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tlcd_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_ok,
   output logic              out_row,
   output logic [3:0]        out_col,
   output logic [7:0]        out_char
);
   import tlcd_pkg::*;

   localparam int DEPTH = 2 * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLUMNS);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

   back_state_type   state_ff, state_in;
   logic             row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic             rsp_row_ff, rsp_row_in;
   logic [3:0]       rsp_col_ff, rsp_col_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             out_free;
   logic             ok;
   logic             load;
   logic [CW+3:0]    col_wide;
   logic [CW+3:0]    tcol_wide;
   logic [CW-1:0]    tcol;
   logic [AW-1:0]    cur_addr;
   logic [AW-1:0]    tgt_addr;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       rd_data;

   function automatic logic [AW-1:0] cell_addr(input logic row, input logic [CW-1:0] col);
      logic [AW-1:0] base;
      base = row ? AW'(COLUMNS) : '0;
      return base + AW'(col);
   endfunction

   assign tcol_wide = (CW + 4)'(cmd.col);
   assign tcol      = tcol_wide[CW-1:0];
   assign cur_addr  = cell_addr(row_ff, col_ff);
   assign tgt_addr  = cell_addr(cmd.row, tcol);
   assign out_free  = !rsp_valid_ff || out_ready;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      ok           = 1'b0;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_char_in  = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               load    = 1'b1;
               case (cmd.op)
                  OP_WRITE: begin
                     wr_en              = 1'b1;
                     valid_in[cur_addr] = 1'b1;
                     ok                 = 1'b1;
                     if (col_ff != LAST_COL) begin
                        col_in = col_ff + 1'b1;
                     end else if (!row_ff) begin
                        row_in = 1'b1;
                        col_in = '0;
                     end
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                     row_in   = 1'b0;
                     col_in   = '0;
                     ok       = 1'b1;
                  end
                  OP_EOL: begin
                     ok = 1'b1;
                     for (int r = 0; r < 2; r++) begin
                        for (int c = 0; c < COLUMNS; c++) begin
                           if ((1'(r) == row_ff) && (CW'(c) >= col_ff)) begin
                              valid_in[r * COLUMNS + c] = 1'b0;
                           end
                        end
                     end
                  end
                  OP_UP: begin
                     ok     = row_ff;
                     row_in = 1'b0;
                  end
                  OP_DOWN: begin
                     ok     = !row_ff;
                     row_in = 1'b1;
                  end
                  OP_RIGHT: begin
                     if (col_ff != LAST_COL) begin
                        col_in = col_ff + 1'b1;
                        ok     = 1'b1;
                     end else if (!row_ff) begin
                        row_in = 1'b1;
                        col_in = '0;
                        ok     = 1'b1;
                     end
                  end
                  OP_LEFT: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        ok     = 1'b1;
                     end else if (row_ff) begin
                        row_in = 1'b0;
                        col_in = LAST_COL;
                        ok     = 1'b1;
                     end
                  end
                  OP_SET: begin
                     row_in = cmd.row;
                     col_in = tcol;
                     ok     = 1'b1;
                  end
                  OP_READ: begin
                     rd_en    = 1'b1;
                     hit_in   = valid_ff[tgt_addr];
                     load     = 1'b0;
                     state_in = ST_READ;
                  end
                  default: begin
                     ok = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load        = 1'b1;
               ok          = 1'b1;
               rsp_char_in = hit_ff ? rd_data : SPACE_CODE;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign col_wide   = (CW + 4)'(col_in);
   assign rsp_ok_in  = ok;
   assign rsp_row_in = row_in;
   assign rsp_col_in = col_wide[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= 1'b0;
         col_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (load) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_char_ff <= rsp_char_in;
      end
   end

   tlcd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_addr),
      .wr_data (cmd.char_code),
      .rd_en   (rd_en),
      .rd_addr (tgt_addr),
      .rd_data (rd_data)
   );

   assign out_valid = rsp_valid_ff;
   assign out_ok    = rsp_ok_ff;
   assign out_row   = rsp_row_ff;
   assign out_col   = rsp_col_ff;
   assign out_char  = rsp_char_ff;

endmodule

/* rtl/two_line_char_display_cursor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-line character display buffer with cursor
// Pipeline: an accepted command item is held in the front-end queue, then
// executed and its result registered for the response output; a read cell
// command adds the registered store read and a read state of the execute stage.
// Throughput: one item per cycle while results are taken and no read is pending.
// Clear and clear to end of line act on per-cell valid flags.
// Reset: synchronous; all cells read as space, cursor at row 0, column 0.
// ----------------------------------------------------------------------------
module two_line_char_display_cursor_top #(
   parameter int COLUMNS = tlcd_pkg::DEF_COLUMNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[3:0], char_code[11:4], target_row[12], target_column[16:13]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], cursor_row[1], cursor_column[5:2], read_char[13:6]
   output logic [15:0] rsp_tdata
);
   import tlcd_pkg::*;

   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic       rsp_ok;
   logic       rsp_row;
   logic [3:0] rsp_col;
   logic [7:0] rsp_char;

   tlcd_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tdata[3:0]),
      .in_char   (req_tdata[11:4]),
      .in_row    (req_tdata[12]),
      .in_col    (req_tdata[16:13]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tlcd_back #(
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ok    (rsp_ok),
      .out_row   (rsp_row),
      .out_col   (rsp_col),
      .out_char  (rsp_char)
   );

   assign rsp_tdata = {2'b00, rsp_char, rsp_col, rsp_row, rsp_ok};

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command queue popped while empty");

   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cmd_valid)
      else $error("queue refuses items while holding none");

   a_char_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_char != 8'd0)) |-> rsp_ok)
      else $error("read character returned on a refused command");

endmodule
